// ----- hdl/vcr_pkg.sv -----
// shared constants, types and helpers of the voxel cushion remover
// no dependencies; every other file of the block but vcr_ram imports this package
package vcr_pkg;

	// volume geometry
	localparam int MAX_WIDTH = 1024;
	localparam int DELAY_CAP = MAX_WIDTH + 2;
	localparam int CODE_W    = 8;
	localparam int DEN_W     = 32;
	localparam int CNT_W     = 11;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LB_AW     = $clog2(MAX_WIDTH);
	localparam int DL_AW     = $clog2(DELAY_CAP + 1);
	localparam int SIZE_MAX  = (1 << CNT_W) - 1;
	localparam int WIDTH_CAP = (MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CUSHION     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AIR         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AIR_DENSITY = 3'd6;

	// input word commands
	localparam logic CMD_VOXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] cushion;
		logic [CODE_W-1:0] air;
		logic [CODE_W-1:0] skin;
	} codes_t;

	// raster position of one voxel
	typedef struct packed {
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] slc;
		logic             last;
	} pos_t;

	// one line buffer entry: media of the two rows above
	typedef struct packed {
		logic [CODE_W-1:0] upper;
		logic [CODE_W-1:0] middle;
	} lb_t;

	// one delay line entry, the end of volume flag lives in its own memory
	typedef struct packed {
		logic [CODE_W-1:0] med_code;
		logic [DEN_W-1:0]  density;
		logic              cleared;
	} dl_entry_t;

	// word held in the window stage, handed to the delay line
	typedef struct packed {
		logic              valid;
		logic              drain;
		logic [CODE_W-1:0] med_code;
		logic [DEN_W-1:0]  density;
		logic              last;
		logic              hit;
	} job_t;

	// delay line handshake back to the window stage
	typedef struct packed {
		logic advance;
		logic hold;
	} dl_ctl_t;

	// a size of zero acts as one, a size beyond the cap saturates
	function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > cap) begin
			r = cap;
		end
		return r;
	endfunction

	// medium that may sit next to a cushion voxel that gets cleared
	function automatic logic is_ok(input logic [CODE_W-1:0] m, input codes_t c);
		return (m == c.cushion) || (m == c.air) || (m == c.skin);
	endfunction

endpackage

// ----- hdl/voxel_cushion_remover.sv -----
// Voxel cushion remover: takes one word per clock (voxel or drain) unless stalled, and
// gives at most one result word per input word. A voxel leaves once width+1 newer voxels
// have entered, or earlier through a drain word. The sustained rate is one word per
// cycle while the output is not blocked, set by the window stage, which reads the line
// buffer ram and the delay line ram once and writes each once per word. A word holds
// the input longer only when it clears a voxel that is not the oldest pending one (possible
// after the width shrinks with voxels still held), since the delay ram has a single
// write port. Rams start undefined and need no clearing pass after reset.
// depends on vcr_pkg, vcr_ram, vcr_raster, vcr_window and vcr_delay
module voxel_cushion_remover (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [vcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vcr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [vcr_pkg::CODE_W-1:0]    medium_in,
	input  logic [vcr_pkg::DEN_W-1:0]     density_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vcr_pkg::CODE_W-1:0]    medium_out,
	output logic [vcr_pkg::DEN_W-1:0]     density_out,
	output logic                          cleared,
	output logic                          end_of_volume
);
	import vcr_pkg::*;

	codes_t            codes_q;
	logic [CNT_W-1:0]  width_q, height_q, depth_q, w_eff, h_eff, d_eff;
	logic [DEN_W-1:0]  air_density_q;
	logic              accept, step, hit;
	pos_t              pos, pos_s1;
	logic              valid_s1, drain_s1;
	logic [CODE_W-1:0] medium_s1;
	logic [DEN_W-1:0]  density_s1;
	job_t              job;
	dl_ctl_t           dctl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q       <= '0;
			width_q       <= CNT_W'(1);
			height_q      <= CNT_W'(1);
			depth_q       <= CNT_W'(1);
			air_density_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CUSHION:     codes_q.cushion <= cfg_data[CODE_W-1:0];
				REG_AIR:         codes_q.air     <= cfg_data[CODE_W-1:0];
				REG_SKIN:        codes_q.skin    <= cfg_data[CODE_W-1:0];
				REG_WIDTH:       width_q         <= cfg_data[CNT_W-1:0];
				REG_HEIGHT:      height_q        <= cfg_data[CNT_W-1:0];
				REG_DEPTH:       depth_q         <= cfg_data[CNT_W-1:0];
				REG_AIR_DENSITY: air_density_q   <= cfg_data[DEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_size(width_q, CNT_W'(WIDTH_CAP));
	assign h_eff = eff_size(height_q, CNT_W'(SIZE_MAX));
	assign d_eff = eff_size(depth_q, CNT_W'(SIZE_MAX));

	// input handshake
	assign in_ready = !dctl.hold && (!valid_s1 || dctl.advance);
	assign accept   = in_valid && in_ready;
	assign step     = accept && (command == CMD_VOXEL);

	vcr_raster u_raster (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.w     (w_eff),
		.h     (h_eff),
		.d     (d_eff),
		.pos   (pos)
	);

	// window stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (dctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drain_s1   <= command;
			medium_s1  <= medium_in;
			density_s1 <= density_in;
			pos_s1     <= pos;
		end
	end

	vcr_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (step),
		.rd_col  (pos.col),
		.shift   (dctl.advance && valid_s1 && (drain_s1 == CMD_VOXEL)),
		.pos     (pos_s1),
		.med_code(medium_s1),
		.codes   (codes_q),
		.d       (d_eff),
		.hit     (hit)
	);

	assign job = '{valid: valid_s1, drain: drain_s1, med_code: medium_s1,
		density: density_s1, last: pos_s1.last, hit: hit};

	vcr_delay u_delay (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.w            (w_eff),
		.codes        (codes_q),
		.air_density  (air_density_q),
		.out_ready    (out_ready),
		.ctl          (dctl),
		.out_valid    (out_valid),
		.medium_out   (medium_out),
		.density_out  (density_out),
		.cleared      (cleared),
		.end_of_volume(end_of_volume)
	);

endmodule

// ----- hdl/vcr_ram.sv -----
// generic single write port ram with one registered read port
// read returns the old word when read and write hit the same address
module vcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// storage and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/vcr_raster.sv -----
// raster counters: column, row and slice of the voxel at the input
// depends on vcr_pkg
module vcr_raster (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [vcr_pkg::CNT_W-1:0] w,
	input  logic [vcr_pkg::CNT_W-1:0] h,
	input  logic [vcr_pkg::CNT_W-1:0] d,
	output vcr_pkg::pos_t            pos
);
	import vcr_pkg::*;

	logic [CNT_W-1:0] col_q, row_q, slc_q;
	logic [CNT_W-1:0] col_e, row_e, slc_e;
	logic [CNT_W:0]   col_inc, row_inc, slc_inc;
	logic [CNT_W-1:0] col_d, row_d, slc_d;

	// counters restart when they sit at or beyond their bound
	always_comb begin
		col_e   = (col_q >= w) ? '0 : col_q;
		row_e   = (row_q >= h) ? '0 : row_q;
		slc_e   = (slc_q >= d) ? '0 : slc_q;
		col_inc = {1'b0, col_e} + 1'b1;
		row_inc = {1'b0, row_e} + 1'b1;
		slc_inc = {1'b0, slc_e} + 1'b1;
		pos.col  = col_e;
		pos.row  = row_e;
		pos.slc  = slc_e;
		pos.last = (col_inc == {1'b0, w}) && (row_inc == {1'b0, h})
			&& (slc_inc == {1'b0, d});
	end

	// advance in raster order on every voxel word
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		slc_d = slc_q;
		if (step) begin
			col_d = CNT_W'(col_inc);
			row_d = row_e;
			slc_d = slc_e;
			if (col_inc >= {1'b0, w}) begin
				col_d = '0;
				row_d = CNT_W'(row_inc);
				if (row_inc >= {1'b0, h}) begin
					row_d = '0;
					slc_d = (slc_inc >= {1'b0, d}) ? '0 : CNT_W'(slc_inc);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			slc_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
			slc_q <= slc_d;
		end
	end

	// column stays inside the row it was counted against
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (col_q < $past(w)))
		else $error("column counter left the row");

	// the final voxel of a volume wraps every counter
	a_volume_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pos.last) |=> (col_q == '0 && row_q == '0 && slc_q == '0))
		else $error("counters did not wrap after the final voxel");

endmodule

// ----- hdl/vcr_window.sv -----
// line buffers of the two rows above and the 3x3 media window with the cushion test
// depends on vcr_pkg and vcr_ram
module vcr_window (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [vcr_pkg::CNT_W-1:0]  rd_col,
	input  logic                      shift,
	input  vcr_pkg::pos_t             pos,
	input  logic [vcr_pkg::CODE_W-1:0] med_code,
	input  vcr_pkg::codes_t           codes,
	input  logic [vcr_pkg::CNT_W-1:0]  d,
	output logic                      hit
);
	import vcr_pkg::*;

	lb_t               lb_rd, lb_eff, lb_wr, fwd_data_q;
	logic              fwd_q;
	logic [CODE_W-1:0] win1_q [3];
	logic [CODE_W-1:0] win2_q [3];
	logic              nb_ok, interior;
	logic [CNT_W:0]    slc_far;

	// line buffer, one entry per column
	vcr_ram #(
		.WIDTH($bits(lb_t)),
		.DEPTH(MAX_WIDTH)
	) u_lb (
		.clk  (clk),
		.we   (shift),
		.waddr(LB_AW'(pos.col)),
		.wdata(lb_wr),
		.re   (rd_en),
		.raddr(LB_AW'(rd_col)),
		.rdata(lb_rd)
	);

	// forward the write that raced the read of the same column
	assign lb_eff = fwd_q ? fwd_data_q : lb_rd;
	assign lb_wr  = '{upper: lb_eff.middle, middle: med_code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= shift && (LB_AW'(pos.col) == LB_AW'(rd_col));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= lb_wr;
		end
	end

	// window columns: win1 is the oldest kept column, the new one comes from the buffer
	always_ff @(posedge clk) begin
		if (shift) begin
			win1_q    <= win2_q;
			win2_q[0] <= lb_eff.upper;
			win2_q[1] <= lb_eff.middle;
			win2_q[2] <= med_code;
		end
	end

	// cushion test on the voxel one row and one column behind
	always_comb begin
		slc_far  = {1'b0, pos.slc} + 2'd2;
		interior = (pos.row >= CNT_W'(2)) && (pos.col >= CNT_W'(2))
			&& (pos.slc >= CNT_W'(1)) && (slc_far <= {1'b0, d});
		nb_ok = is_ok(win1_q[0], codes) && is_ok(win1_q[1], codes)
			&& is_ok(win1_q[2], codes) && is_ok(win2_q[0], codes)
			&& is_ok(win2_q[2], codes) && is_ok(lb_eff.upper, codes)
			&& is_ok(lb_eff.middle, codes) && is_ok(med_code, codes);
		hit = interior && (win2_q[1] == codes.cushion) && nb_ok;
	end

endmodule

// ----- hdl/vcr_delay.sv -----
// delay line of pending voxels in ram, in-place clearing and the result register
// depends on vcr_pkg and vcr_ram
module vcr_delay (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vcr_pkg::job_t             job,
	input  logic [vcr_pkg::CNT_W-1:0]  w,
	input  vcr_pkg::codes_t           codes,
	input  logic [vcr_pkg::DEN_W-1:0]  air_density,
	input  logic                      out_ready,
	output vcr_pkg::dl_ctl_t          ctl,
	output logic                      out_valid,
	output logic [vcr_pkg::CODE_W-1:0] medium_out,
	output logic [vcr_pkg::DEN_W-1:0]  density_out,
	output logic                      cleared,
	output logic                      end_of_volume
);
	import vcr_pkg::*;

	localparam int SW = ((DL_AW > CNT_W) ? DL_AW : CNT_W) + 2;

	logic [DL_AW-1:0] head_q, pending_q, head_d, pending_d;
	logic [DL_AW-1:0] idx, tail, head_inc, clr_idx_q;
	logic             clr_q;
	logic [SW-1:0]    pend, wp1, pend_after, back_off, idx_sum, tail_sum;
	logic             voxel, drain, pop, test, clr_hit, clr_far;
	dl_entry_t        air_entry, push_entry, m_wdata, m_rdata, head_entry, res_q;
	logic             m_we;
	logic [DL_AW-1:0] m_waddr;
	logic [0:0]       l_rdata;
	logic             head_last, eov_q, out_valid_q;
	logic             mwr_valid_q, lwr_valid_q, lwr_data_q;
	logic [DL_AW-1:0] mwr_addr_q, lwr_addr_q;
	dl_entry_t        mwr_data_q;

	// fifo arithmetic, all sums stay below twice the capacity
	always_comb begin
		voxel      = job.valid && (job.drain == CMD_VOXEL);
		drain      = job.valid && (job.drain == CMD_DRAIN);
		pend       = SW'(pending_q);
		wp1        = SW'(w) + SW'(1);
		pend_after = (pend < SW'(DELAY_CAP)) ? pend + SW'(1) : pend;
		back_off   = pend - wp1;
		idx_sum    = SW'(head_q) + back_off;
		idx        = (idx_sum >= SW'(DELAY_CAP)) ? DL_AW'(idx_sum - SW'(DELAY_CAP))
			: DL_AW'(idx_sum);
		tail_sum   = SW'(head_q) + pend;
		tail       = (tail_sum >= SW'(DELAY_CAP)) ? DL_AW'(tail_sum - SW'(DELAY_CAP))
			: DL_AW'(tail_sum);
		head_inc   = (SW'(head_q) + SW'(1) == SW'(DELAY_CAP)) ? '0 : head_q + 1'b1;
		pop        = voxel ? (pend_after > wp1) : (drain && pending_q != '0);
		test       = voxel && job.hit && (pend >= wp1);
		clr_hit    = test && (idx == head_q);
		clr_far    = test && (idx != head_q);
	end

	// stage handshake: stall while the result register is blocked or a late clear is pending
	always_comb begin
		ctl.advance = job.valid && (!pop || !out_valid_q || out_ready);
		ctl.hold    = clr_q || (ctl.advance && clr_far);
		head_d      = (ctl.advance && pop) ? head_inc : head_q;
		pending_d   = pending_q;
		if (ctl.advance) begin
			pending_d = voxel ? DL_AW'(pend_after - SW'(pop)) : DL_AW'(pend - SW'(pop));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			pending_q <= '0;
			clr_q     <= 1'b0;
		end else begin
			head_q    <= head_d;
			pending_q <= pending_d;
			clr_q     <= ctl.advance && clr_far;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && clr_far) begin
			clr_idx_q <= idx;
		end
	end

	// main write port: push of the new voxel, or a late clear in the cycle after its test
	always_comb begin
		air_entry  = '{med_code: codes.air, density: air_density, cleared: 1'b1};
		push_entry = '{med_code: job.med_code, density: job.density, cleared: 1'b0};
		m_we       = clr_q || (ctl.advance && voxel);
		m_waddr    = clr_q ? clr_idx_q : tail;
		m_wdata    = clr_q ? air_entry : push_entry;
	end

	vcr_ram #(
		.WIDTH($bits(dl_entry_t)),
		.DEPTH(DELAY_CAP)
	) u_main (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (1'b1),
		.raddr(head_d),
		.rdata(m_rdata)
	);

	vcr_ram #(
		.WIDTH(1),
		.DEPTH(DELAY_CAP)
	) u_last (
		.clk  (clk),
		.we   (ctl.advance && voxel),
		.waddr(tail),
		.wdata(job.last),
		.re   (1'b1),
		.raddr(head_d),
		.rdata(l_rdata)
	);

	// last write of each ram, forwarded onto the head read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mwr_valid_q <= 1'b0;
			lwr_valid_q <= 1'b0;
		end else begin
			mwr_valid_q <= m_we;
			lwr_valid_q <= ctl.advance && voxel;
		end
	end

	always_ff @(posedge clk) begin
		mwr_addr_q <= m_waddr;
		mwr_data_q <= m_wdata;
		lwr_addr_q <= tail;
		lwr_data_q <= job.last;
	end

	assign head_entry = (mwr_valid_q && mwr_addr_q == head_q) ? mwr_data_q : m_rdata;
	assign head_last  = (lwr_valid_q && lwr_addr_q == head_q) ? lwr_data_q : l_rdata[0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.advance && pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && pop) begin
			res_q <= clr_hit ? air_entry : head_entry;
			eov_q <= head_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign medium_out    = res_q.med_code;
	assign density_out   = res_q.density;
	assign cleared       = res_q.cleared;
	assign end_of_volume = eov_q;

	// the late clear write never shares its cycle with a word in the stage
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !job.valid)
		else $error("late clear overlaps a word");

	// a voxel cleared on its way out leaves as air
	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.advance && clr_hit) |=> (out_valid_q && res_q.cleared))
		else $error("cleared voxel left without its flag");

endmodule
